// ===== rtl/core/pitchpid_pkg.sv =====
`timescale 1ns / 1ps

package pitchpid_pkg;

    // Field and datapath widths
    localparam int GainW   = 32;
    localparam int StepTW  = 16;
    localparam int LimitW  = 15;
    localparam int PitchW  = 16;
    localparam int RateW   = 19;
    localparam int ErrW    = PitchW + 1;
    localparam int DriveW  = 16;
    localparam int IntegW  = 40;
    localparam int FracW   = 16;
    localparam int MulAW   = GainW + 1;
    localparam int MulBW   = RateW + 1;
    localparam int AccW    = MulAW + MulBW;
    localparam int CfgAddrW = 3;
    localparam int InDataW = 56;
    localparam int OutDataW = 16;

    // Reset values of the configuration registers
    localparam logic [StepTW-1:0] StepTimeReset   = StepTW'(328);
    localparam logic [LimitW-1:0] MotorLimitReset = LimitW'(10000);

    // Configuration register indexes
    typedef enum logic [CfgAddrW-1:0] {
        CFG_PROP_GAIN   = 3'd0,
        CFG_INTEG_GAIN  = 3'd1,
        CFG_RATE_GAIN   = 3'd2,
        CFG_STEP_TIME   = 3'd3,
        CFG_MOTOR_LIMIT = 3'd4
    } cfg_idx_t;

    // Microprogram
    localparam int ProgLen = 10;
    localparam int StepW   = $clog2(ProgLen);

    typedef enum logic [2:0] {
        A_INTEG,
        A_PROP,
        A_RATEG,
        A_HI,
        A_PLO
    } mul_a_sel_t;

    typedef enum logic [1:0] {
        B_ERR,
        B_RATE,
        B_STEP
    } mul_b_sel_t;

    typedef enum logic [2:0] {
        ACC_HOLD,
        ACC_LOAD,
        ACC_ADD,
        ACC_ADD_SHR,
        ACC_ADD_INTEG
    } acc_op_t;

    typedef struct packed {
        mul_a_sel_t       mul_a;
        mul_b_sel_t       mul_b;
        logic             mul_en;
        acc_op_t          acc_op;
        logic             plo_ld;
        logic             integ_ld;
        logic             jump_zero;
        logic [StepW-1:0] jump_to;
        logic             emit;
        logic             emit_zero;
    } ucode_t;

    localparam logic [StepW-1:0] StepEmitZero = StepW'(ProgLen - 1);

    // Control store: one word per step
    function automatic ucode_t ucode_rom(input logic [StepW-1:0] addr);
        ucode_t w;
        w = '{mul_a: A_INTEG, mul_b: B_ERR, mul_en: 1'b0, acc_op: ACC_HOLD,
              plo_ld: 1'b0, integ_ld: 1'b0, jump_zero: 1'b0, jump_to: '0,
              emit: 1'b0, emit_zero: 1'b0};
        unique case (addr)
            // p = integ_gain * err; skip everything on a zero step time
            4'd0: begin
                w.mul_a = A_INTEG; w.mul_b = B_ERR; w.mul_en = 1'b1;
                w.jump_zero = 1'b1; w.jump_to = StepEmitZero;
            end
            // upper part of p times step time; hold lower part of p
            4'd1: begin
                w.mul_a = A_HI; w.mul_b = B_STEP; w.mul_en = 1'b1;
                w.plo_ld = 1'b1;
            end
            // lower part of p times step time; load upper partial product
            4'd2: begin
                w.mul_a = A_PLO; w.mul_b = B_STEP; w.mul_en = 1'b1;
                w.acc_op = ACC_LOAD;
            end
            // add floor of lower partial product
            4'd3: w.acc_op = ACC_ADD_SHR;
            // integral + increment; start proportional product
            4'd4: begin
                w.mul_a = A_PROP; w.mul_b = B_ERR; w.mul_en = 1'b1;
                w.acc_op = ACC_ADD_INTEG;
            end
            // clamp into the integral; load proportional term; start rate product
            4'd5: begin
                w.mul_a = A_RATEG; w.mul_b = B_RATE; w.mul_en = 1'b1;
                w.integ_ld = 1'b1; w.acc_op = ACC_LOAD;
            end
            4'd6: w.acc_op = ACC_ADD;
            4'd7: w.acc_op = ACC_ADD_INTEG;
            4'd8: w.emit = 1'b1;
            4'd9: begin
                w.emit = 1'b1; w.emit_zero = 1'b1;
            end
            default: w.emit = 1'b1;
        endcase
        return w;
    endfunction

endpackage

// ===== rtl/core/pitch_angle_pid_with_rate_feedback.sv =====
`timescale 1ns / 1ps

// Pitch angle PID with gyro rate feedback. Each input transaction carries the
// measured pitch, the gyro pitch rate and the target pitch; one output
// transaction returns the clamped motor drive. Error is measured minus target;
// the integral gains integ_gain*error*step_time (Q16.16, floored) and is
// clamped to plus or minus motor_limit, and drive is the floored sum of the
// proportional, integral and rate terms, clamped the same way. A zero step
// time gives drive 0 and leaves the integral alone. A microprogram runs all
// five products through a single shared 33x20 multiplier: the result is
// registered at the output step, and the next sample is accepted only once
// that step has run. The next sample is accepted even while the previous
// result still waits on m_tready; its program then holds at the output step
// until that result is taken. Configuration is written through cfg_we/
// cfg_addr/cfg_wdata; the user must do so only while the block is idle, as
// the block itself does not enforce it.
module pitch_angle_pid_with_rate_feedback
    import pitchpid_pkg::*;
(
    input  logic                aclk,
    input  logic                aresetn,
    // configuration write port
    input  logic                cfg_we,
    input  logic [CfgAddrW-1:0] cfg_addr,
    input  logic [GainW-1:0]    cfg_wdata,
    // input stream
    input  logic                s_tvalid,
    output logic                s_tready,
    // measured_pitch [15:0], pitch_rate [34:16], target_pitch [50:35], zeros
    input  logic [InDataW-1:0]  s_tdata,
    // result stream
    output logic                m_tvalid,
    input  logic                m_tready,
    // drive [15:0]
    output logic [OutDataW-1:0] m_tdata
);

    // Configuration registers
    logic signed [GainW-1:0]  prop_gain_reg;
    logic signed [GainW-1:0]  integ_gain_reg;
    logic signed [GainW-1:0]  rate_gain_reg;
    logic        [StepTW-1:0] step_time_reg;
    logic        [LimitW-1:0] motor_limit_reg;

    // Sequencer and datapath
    logic                     busy_reg, busy_next;
    logic [StepW-1:0]         step_reg, step_next;
    logic signed [ErrW-1:0]   err_reg;
    logic signed [RateW-1:0]  rate_reg;
    logic signed [AccW-1:0]   prod_reg;
    logic signed [AccW-1:0]   acc_reg, acc_next;
    logic [FracW-1:0]         plo_reg;
    logic signed [IntegW-1:0] integ_reg, integ_next;
    logic                     m_tvalid_reg;
    logic [DriveW-1:0]        drive_reg, drive_next;

    ucode_t                   uw;
    logic                     s_fire;
    logic                     exec;
    logic signed [MulAW-1:0]  mul_a;
    logic signed [MulBW-1:0]  mul_b;
    logic signed [AccW-1:0]   mul_prod;
    logic signed [AccW-1:0]   lim_q;
    logic signed [AccW-1:0]   drive_full;
    logic signed [AccW-1:0]   lim_s;
    logic signed [PitchW-1:0] in_meas;
    logic signed [PitchW-1:0] in_targ;

    assign s_tready = !busy_reg;
    assign s_fire   = s_tvalid && s_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = drive_reg;
    assign in_meas  = s_tdata[PitchW-1:0];
    assign in_targ  = s_tdata[PitchW+RateW+PitchW-1:PitchW+RateW];

    assign uw = ucode_rom(step_reg);
    // stall the output step while the previous result is still unread
    assign exec = busy_reg && !(uw.emit && m_tvalid_reg && !m_tready);

    // Write configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            prop_gain_reg   <= '0;
            integ_gain_reg  <= '0;
            rate_gain_reg   <= '0;
            step_time_reg   <= StepTimeReset;
            motor_limit_reg <= MotorLimitReset;
        end else if (cfg_we) begin
            case (cfg_addr)
                CFG_PROP_GAIN:   prop_gain_reg   <= cfg_wdata;
                CFG_INTEG_GAIN:  integ_gain_reg  <= cfg_wdata;
                CFG_RATE_GAIN:   rate_gain_reg   <= cfg_wdata;
                CFG_STEP_TIME:   step_time_reg   <= cfg_wdata[StepTW-1:0];
                CFG_MOTOR_LIMIT: motor_limit_reg <= cfg_wdata[LimitW-1:0];
                default: ;
            endcase
        end
    end

    // Select multiplier operands
    always_comb begin
        case (uw.mul_a)
            A_INTEG: mul_a = MulAW'(integ_gain_reg);
            A_PROP:  mul_a = MulAW'(prop_gain_reg);
            A_RATEG: mul_a = MulAW'(rate_gain_reg);
            A_HI:    mul_a = prod_reg[FracW+MulAW-1:FracW];
            A_PLO:   mul_a = $signed({{(MulAW-FracW){1'b0}}, plo_reg});
            default: mul_a = '0;
        endcase
        case (uw.mul_b)
            B_ERR:   mul_b = MulBW'(err_reg);
            B_RATE:  mul_b = MulBW'(rate_reg);
            B_STEP:  mul_b = $signed({{(MulBW-StepTW){1'b0}}, step_time_reg});
            default: mul_b = '0;
        endcase
    end

    assign mul_prod = AccW'(mul_a) * AccW'(mul_b);

    // Accumulator, integral clamp and drive clamp
    always_comb begin
        case (uw.acc_op)
            ACC_LOAD:      acc_next = prod_reg;
            ACC_ADD:       acc_next = acc_reg + prod_reg;
            ACC_ADD_SHR:   acc_next = acc_reg + (prod_reg >>> FracW);
            ACC_ADD_INTEG: acc_next = acc_reg + AccW'(integ_reg);
            default:       acc_next = acc_reg;
        endcase

        lim_q = $signed({{(AccW-LimitW-FracW){1'b0}}, motor_limit_reg, {FracW{1'b0}}});
        if (acc_reg > lim_q) begin
            integ_next = IntegW'(lim_q);
        end else if (acc_reg < -lim_q) begin
            integ_next = IntegW'(-lim_q);
        end else begin
            integ_next = IntegW'(acc_reg);
        end

        lim_s      = $signed({{(AccW-LimitW){1'b0}}, motor_limit_reg});
        drive_full = acc_reg >>> FracW;
        if (uw.emit_zero) begin
            drive_next = '0;
        end else if (drive_full > lim_s) begin
            drive_next = DriveW'(lim_s);
        end else if (drive_full < -lim_s) begin
            drive_next = DriveW'(-lim_s);
        end else begin
            drive_next = DriveW'(drive_full);
        end
    end

    // Advance the step counter
    always_comb begin
        busy_next = busy_reg;
        step_next = step_reg;
        if (s_fire) begin
            busy_next = 1'b1;
            step_next = '0;
        end else if (exec) begin
            if (uw.emit) begin
                busy_next = 1'b0;
                step_next = '0;
            end else if (uw.jump_zero && step_time_reg == '0) begin
                step_next = uw.jump_to;
            end else begin
                step_next = step_reg + StepW'(1);
            end
        end
    end

    // Control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg     <= 1'b0;
            step_reg     <= '0;
            m_tvalid_reg <= 1'b0;
            integ_reg    <= '0;
        end else begin
            busy_reg <= busy_next;
            step_reg <= step_next;
            if (exec && uw.emit) begin
                m_tvalid_reg <= 1'b1;
            end else if (m_tready) begin
                m_tvalid_reg <= 1'b0;
            end
            if (exec && uw.integ_ld) begin
                integ_reg <= integ_next;
            end
        end
    end

    // Datapath registers
    always_ff @(posedge aclk) begin
        if (s_fire) begin
            err_reg  <= ErrW'(in_meas) - ErrW'(in_targ);
            rate_reg <= s_tdata[PitchW+RateW-1:PitchW];
        end
        if (exec) begin
            if (uw.mul_en) begin
                prod_reg <= mul_prod;
            end
            if (uw.plo_ld) begin
                plo_reg <= prod_reg[FracW-1:0];
            end
            acc_reg <= acc_next;
            if (uw.emit) begin
                drive_reg <= drive_next;
            end
        end
    end

`ifndef SYNTH
    // A new sample always starts the program at its first step
    a_start: assert property (@(posedge aclk) disable iff (!aresetn)
        s_fire |=> busy_reg && step_reg == '0)
        else $error("sample accepted without restarting the sequencer");

    // The step counter never leaves the control store
    a_step_range: assert property (@(posedge aclk) disable iff (!aresetn)
        busy_reg |-> (int'(step_reg) < ProgLen))
        else $error("step counter beyond the microprogram");

    // A result only appears from a running program
    a_result_src: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_tvalid_reg) |-> $past(busy_reg) && !busy_reg)
        else $error("result raised without a finished program");
`endif

endmodule
